// ===== hw/rtl/srrs_pkg.sv =====
// shared types and constants of the spi radio register sequencer
`timescale 1ns / 1ps

package srrs_pkg;

  localparam int MaxPayload = 64;
  localparam int IdxW       = $clog2(MaxPayload);
  localparam int CntW       = $clog2(MaxPayload + 1);

  localparam logic [7:0] WriteBit    = 8'b1000_0000;
  localparam logic [7:0] AddrMask    = 8'b0111_1111;
  localparam logic [7:0] RxModeValue = 8'b0001_0000;
  localparam logic [1:0] JoinCount   = 2'd2;

  typedef enum logic [2:0] {
    FN_READ_REG  = 3'd0,
    FN_WRITE_REG = 3'd1,
    FN_FIFO_READ = 3'd2,
    FN_FIFO_WRITE = 3'd3,
    FN_SPI_RX    = 3'd4,
    FN_SPI_TX    = 3'd5,
    FN_DONE_PIN  = 3'd6,
    FN_LOAD_BYTE = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_FIFO   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PAYLOAD_LEN = 2'd0,
    CFG_FIFO_ADDR   = 2'd1,
    CFG_MODE_ADDR   = 2'd2
  } cfg_idx_e;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_RS_CMD = 9'b000000010,
    PH_RS_DAT = 9'b000000100,
    PH_WS_CMD = 9'b000001000,
    PH_WS_DAT = 9'b000010000,
    PH_RF_CMD = 9'b000100000,
    PH_RF_DAT = 9'b001000000,
    PH_WF_CMD = 9'b010000000,
    PH_WF_DAT = 9'b100000000
  } phase_e;

  typedef struct packed {
    func_e             func;
    logic [6:0]        reg_addr;
    logic [7:0]        data_in;
    logic [IdxW-1:0]   load_index;
  } req_t;

  typedef struct packed {
    logic            accepted;
    logic            send_valid;
    logic [7:0]      send_byte;
    logic            select_level;
    logic            busy_res;
    kind_e           data_kind;
    logic [7:0]      data_byte;
    logic [IdxW-1:0] data_index;
    logic            receive_done;
    logic            transmit_done;
  } rsp_t;

endpackage

// ===== hw/rtl/srrs_if.sv =====
// request and result channel interfaces of the sequencer
`timescale 1ns / 1ps

interface srrs_req_if import srrs_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srrs_rsp_if import srrs_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/spi_radio_register_sequencer_top.sv =====
// spi radio register sequencer: transaction state, payload memory and result register
// the result of a request is registered and valid on the cycle after it is taken
// throughput: one request per cycle; a request waits only while an unread result is held
// the payload byte for a send is read ahead into a register from the payload memory port
// reset: phase idle, join count and indexes zero, chip select high, config to defaults
// the payload memory is not cleared and holds garbage until loaded
`timescale 1ns / 1ps

module spi_radio_register_sequencer_top import srrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [6:0]     cfg_data_i,
  srrs_req_if.sink       req_i,
  srrs_rsp_if.source     rsp_o
);

  logic [6:0] payload_len_q, fifo_addr_q, mode_addr_q;

  phase_e          phase_q, phase_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [CntW-1:0] send_idx_q, send_idx_d;
  logic [CntW-1:0] recv_idx_q, recv_idx_d;
  logic [7:0]      single_q, single_d;
  logic            expect_q, expect_d;
  logic            select_q, select_d;

  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic [7:0]      mem_q [MaxPayload];
  logic [7:0]      rd_q;
  logic            mem_we;
  logic [IdxW-1:0] raddr;

  logic            take;
  logic [CntW-1:0] len;
  logic [CntW-1:0] sidx;
  logic            spi;
  logic            cmd_ph;
  logic            rd_ph;
  req_t            rq;

  assign rq          = req_i.data;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign take        = req_i.valid && req_i.ready;

  // effective payload length: zero is taken as one, larger values saturate at MaxPayload
  always_comb begin
    if (payload_len_q == 7'd0) begin
      len = CntW'(1);
    end else if (CntW'(payload_len_q) > CntW'(MaxPayload)) begin
      len = CntW'(MaxPayload);
    end else begin
      len = CntW'(payload_len_q);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    send_idx_d = send_idx_q;
    recv_idx_d = recv_idx_q;
    single_d   = single_q;
    expect_d   = expect_q;
    select_d   = select_q;
    rsp_d      = '0;
    mem_we     = 1'b0;
    spi        = 1'b0;
    sidx       = send_idx_q;
    cmd_ph     = (phase_q == PH_RF_CMD) || (phase_q == PH_WF_CMD);
    rd_ph      = (phase_q == PH_RF_CMD) || (phase_q == PH_RF_DAT);
    if (take) begin
      case (rq.func)
        FN_READ_REG: begin
          if (phase_q == PH_IDLE) begin
            phase_d = PH_RS_CMD;
            select_d = 1'b0;
            rsp_d.send_valid = 1'b1;
            rsp_d.send_byte = {1'b0, rq.reg_addr};
            rsp_d.accepted = 1'b1;
          end
        end
        FN_WRITE_REG: begin
          if (phase_q == PH_IDLE) begin
            single_d = rq.data_in;
            phase_d = PH_WS_CMD;
            select_d = 1'b0;
            rsp_d.send_valid = 1'b1;
            rsp_d.send_byte = {1'b0, rq.reg_addr} | WriteBit;
            rsp_d.accepted = 1'b1;
          end
        end
        FN_FIFO_READ: begin
          if (phase_q == PH_IDLE) begin
            phase_d = PH_RF_CMD;
            select_d = 1'b0;
            rsp_d.send_valid = 1'b1;
            rsp_d.send_byte = {1'b0, fifo_addr_q};
            rsp_d.accepted = 1'b1;
          end
        end
        FN_FIFO_WRITE: begin
          if (phase_q == PH_IDLE) begin
            expect_d = 1'b1;
            phase_d = PH_WF_CMD;
            select_d = 1'b0;
            rsp_d.send_valid = 1'b1;
            rsp_d.send_byte = {1'b0, fifo_addr_q} | WriteBit;
            rsp_d.accepted = 1'b1;
          end
        end
        FN_SPI_RX: begin
          spi = 1'b1;
          case (phase_q)
            PH_IDLE: begin
            end
            PH_RS_DAT: begin
              single_d = rq.data_in;
              rsp_d.data_kind = KIND_SINGLE;
              rsp_d.data_byte = rq.data_in;
              cnt_d = cnt_q + 2'd1;
            end
            PH_WS_DAT: begin
              cnt_d = cnt_q + 2'd1;
            end
            PH_RF_DAT, PH_WF_DAT: begin
              if (recv_idx_q < len) begin
                if (phase_q == PH_RF_DAT) begin
                  rsp_d.data_kind = KIND_FIFO;
                  rsp_d.data_byte = rq.data_in;
                  rsp_d.data_index = recv_idx_q[IdxW-1:0];
                end
                recv_idx_d = recv_idx_q + CntW'(1);
                if (recv_idx_d == len) begin
                  cnt_d = cnt_q + 2'd1;
                end
              end
            end
            default: begin
              cnt_d = cnt_q + 2'd1;
              recv_idx_d = '0;
            end
          endcase
        end
        FN_SPI_TX: begin
          spi = 1'b1;
          case (phase_q)
            PH_RS_CMD: begin
              rsp_d.send_valid = 1'b1;
              cnt_d = cnt_q + 2'd1;
            end
            PH_RS_DAT, PH_WS_DAT: begin
              cnt_d = cnt_q + 2'd1;
            end
            PH_WS_CMD: begin
              rsp_d.send_valid = 1'b1;
              rsp_d.send_byte = single_q;
              cnt_d = cnt_q + 2'd1;
            end
            PH_RF_CMD, PH_RF_DAT, PH_WF_CMD, PH_WF_DAT: begin
              if (cmd_ph) begin
                sidx = '0;
              end
              cnt_d = cnt_q + {1'b0, cmd_ph};
              if (sidx >= len) begin
                cnt_d = cnt_d + 2'd1;
              end else begin
                rsp_d.send_valid = 1'b1;
                rsp_d.send_byte = rd_ph ? 8'd0 : rd_q;
              end
              send_idx_d = (sidx >= len) ? sidx : sidx + CntW'(1);
            end
            default: begin
            end
          endcase
        end
        FN_DONE_PIN: begin
          if (expect_q) begin
            rsp_d.transmit_done = 1'b1;
            expect_d = 1'b0;
          end else if (phase_q == PH_IDLE) begin
            phase_d = PH_RF_CMD;
            select_d = 1'b0;
            rsp_d.send_valid = 1'b1;
            rsp_d.send_byte = {1'b0, fifo_addr_q};
            rsp_d.accepted = 1'b1;
          end
        end
        default: begin
          mem_we = 1'b1;
        end
      endcase

      if (spi) begin
        if (cnt_d >= JoinCount) begin
          cnt_d = '0;
          case (phase_q)
            PH_RS_DAT, PH_WS_DAT: phase_d = PH_IDLE;
            PH_RF_DAT: begin
              phase_d = PH_IDLE;
              rsp_d.receive_done = 1'b1;
            end
            PH_WF_DAT: begin
              // chained write of receive mode to the mode register
              single_d = RxModeValue;
              phase_d = PH_WS_CMD;
              select_d = 1'b0;
              rsp_d.send_valid = 1'b1;
              rsp_d.send_byte = {1'b0, mode_addr_q} | WriteBit;
            end
            PH_RS_CMD: phase_d = PH_RS_DAT;
            PH_WS_CMD: phase_d = PH_WS_DAT;
            PH_RF_CMD: phase_d = PH_RF_DAT;
            PH_WF_CMD: phase_d = PH_WF_DAT;
            default: begin
            end
          endcase
        end
        if (phase_d == PH_IDLE) begin
          select_d = 1'b1;
        end
      end
      rsp_d.select_level = select_d;
      rsp_d.busy_res = (phase_d != PH_IDLE);
    end
  end

  // next payload byte to send
  assign raddr = (phase_d == PH_WF_CMD) ? '0 : send_idx_d[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[rq.load_index] <= rq.data_in;
    end
    if (mem_we && (rq.load_index == raddr)) begin
      rd_q <= rq.data_in;
    end else begin
      rd_q <= mem_q[raddr];
    end
  end

  assign rsp_valid_d = take || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      payload_len_q <= 7'd16;
      fifo_addr_q   <= 7'd0;
      mode_addr_q   <= 7'd1;
      phase_q       <= PH_IDLE;
      cnt_q         <= '0;
      send_idx_q    <= '0;
      recv_idx_q    <= '0;
      single_q      <= '0;
      expect_q      <= 1'b0;
      select_q      <= 1'b1;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PAYLOAD_LEN: payload_len_q <= cfg_data_i;
          CFG_FIFO_ADDR:   fifo_addr_q   <= cfg_data_i;
          CFG_MODE_ADDR:   mode_addr_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      send_idx_q  <= send_idx_d;
      recv_idx_q  <= recv_idx_d;
      single_q    <= single_d;
      expect_q    <= expect_d;
      select_q    <= select_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the spi radio register sequencer: directed script, random traffic, predictor
`timescale 1ns / 1ps

module tb_top;
  import srrs_pkg::*;

  localparam int MaxCycles = 400000;
  localparam int SettingCount = 7;
  localparam int ItemsPerSetting = 1450 / SettingCount;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [6:0] cfg_data_i;

  srrs_req_if req_if ();
  srrs_rsp_if rsp_if ();

  spi_radio_register_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  // sequencer shadow state
  phase_e     seq_ph;
  int         join_cnt;
  int         tx_idx;
  int         rx_idx;
  logic [7:0] reg_val;
  bit         tx_pending;
  logic       cs_level;
  logic [7:0] payload_mem [MaxPayload];
  bit         loaded [MaxPayload];
  logic [6:0] cfg_len;
  logic [6:0] cfg_fifo;
  logic [6:0] cfg_mode;

  rsp_t expected_q [$];
  int   gap_pct = 12;
  int   mismatches = 0;
  int   cycles = 0;
  int   n_req = 0;
  int   n_checked = 0;
  int   n_rx_done = 0;
  int   n_tx_done = 0;
  int   n_refused = 0;
  int   n_settings = 0;
  bit   last_counted;

  typedef struct {
    bit         is_cfg;
    logic [6:0] len;
    req_t       r;
    bit         typed;
    rsp_t       want;
  } script_row_t;

  script_row_t script [$];

  function automatic int frame_len();
    int n;
    n = cfg_len;
    if (n < 1) n = 1;
    if (n > MaxPayload) n = MaxPayload;
    return n;
  endfunction

  function automatic void open_frame(input phase_e p, input logic [7:0] cmd, inout rsp_t e);
    seq_ph = p;
    cs_level = 1'b0;
    e.send_valid = 1'b1;
    e.send_byte = cmd;
  endfunction

  task automatic advance_sequencer(input req_t r, output rsp_t e);
    bit spi;
    int len;
    e = '0;
    spi = 1'b0;
    len = frame_len();
    case (r.func)
      FN_READ_REG: if (seq_ph == PH_IDLE) begin
        open_frame(PH_RS_CMD, {1'b0, r.reg_addr}, e);
        e.accepted = 1'b1;
      end
      FN_WRITE_REG: if (seq_ph == PH_IDLE) begin
        reg_val = r.data_in;
        open_frame(PH_WS_CMD, {1'b0, r.reg_addr} | WriteBit, e);
        e.accepted = 1'b1;
      end
      FN_FIFO_READ: if (seq_ph == PH_IDLE) begin
        open_frame(PH_RF_CMD, {1'b0, cfg_fifo}, e);
        e.accepted = 1'b1;
      end
      FN_FIFO_WRITE: if (seq_ph == PH_IDLE) begin
        tx_pending = 1'b1;
        open_frame(PH_WF_CMD, {1'b0, cfg_fifo} | WriteBit, e);
        e.accepted = 1'b1;
      end
      FN_SPI_RX: begin
        spi = 1'b1;
        case (seq_ph)
          PH_IDLE: ;
          PH_RS_DAT: begin
            reg_val = r.data_in;
            e.data_kind = KIND_SINGLE;
            e.data_byte = r.data_in;
            join_cnt++;
          end
          PH_WS_DAT: join_cnt++;
          PH_RF_DAT, PH_WF_DAT: begin
            // bytes past the frame length are dropped
            if (rx_idx < len) begin
              if (seq_ph == PH_RF_DAT) begin
                e.data_kind = KIND_FIFO;
                e.data_byte = r.data_in;
                e.data_index = IdxW'(rx_idx);
              end
              rx_idx++;
              if (rx_idx == len) join_cnt++;
            end
          end
          default: begin
            join_cnt++;
            rx_idx = 0;
          end
        endcase
      end
      FN_SPI_TX: begin
        spi = 1'b1;
        case (seq_ph)
          PH_RS_CMD: begin
            e.send_valid = 1'b1;
            e.send_byte = 8'h00;
            join_cnt++;
          end
          PH_RS_DAT, PH_WS_DAT: join_cnt++;
          PH_WS_CMD: begin
            e.send_valid = 1'b1;
            e.send_byte = reg_val;
            join_cnt++;
          end
          PH_RF_CMD, PH_RF_DAT, PH_WF_CMD, PH_WF_DAT: begin
            if (seq_ph == PH_RF_CMD || seq_ph == PH_WF_CMD) begin
              tx_idx = 0;
              join_cnt++;
            end
            if (tx_idx >= len) begin
              join_cnt++;
            end else begin
              e.send_valid = 1'b1;
              e.send_byte = (seq_ph == PH_RF_CMD || seq_ph == PH_RF_DAT) ? 8'h00
                                                                        : payload_mem[tx_idx];
              tx_idx++;
            end
          end
          default: ;
        endcase
      end
      FN_DONE_PIN: begin
        if (tx_pending) begin
          e.transmit_done = 1'b1;
          tx_pending = 1'b0;
        end else if (seq_ph == PH_IDLE) begin
          open_frame(PH_RF_CMD, {1'b0, cfg_fifo}, e);
          e.accepted = 1'b1;
        end
      end
      default: begin
        payload_mem[r.load_index] = r.data_in;
        loaded[r.load_index] = 1'b1;
      end
    endcase

    if (spi) begin
      if (join_cnt >= JoinCount) begin
        join_cnt = 0;
        case (seq_ph)
          PH_RS_DAT, PH_WS_DAT: seq_ph = PH_IDLE;
          PH_RF_DAT: begin
            seq_ph = PH_IDLE;
            e.receive_done = 1'b1;
          end
          PH_WF_DAT: begin
            // payload out, chain the receive mode write
            reg_val = RxModeValue;
            open_frame(PH_WS_CMD, {1'b0, cfg_mode} | WriteBit, e);
          end
          PH_RS_CMD: seq_ph = PH_RS_DAT;
          PH_WS_CMD: seq_ph = PH_WS_DAT;
          PH_RF_CMD: seq_ph = PH_RF_DAT;
          PH_WF_CMD: seq_ph = PH_WF_DAT;
          default: ;
        endcase
      end
      if (seq_ph == PH_IDLE) cs_level = 1'b1;
    end
    e.select_level = cs_level;
    e.busy_res = (seq_ph != PH_IDLE);
  endtask

  function automatic req_t mk_req(input func_e f, input logic [6:0] addr, input logic [7:0] d,
                                  input logic [IdxW-1:0] idx);
    req_t r;
    r.func = f;
    r.reg_addr = addr;
    r.data_in = d;
    r.load_index = idx;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic acc, input logic sv, input logic [7:0] sb,
                                  input logic sel, input logic busy, input logic txd);
    rsp_t e;
    e = '0;
    e.data_kind = KIND_NONE;
    e.accepted = acc;
    e.send_valid = sv;
    e.send_byte = sb;
    e.select_level = sel;
    e.busy_res = busy;
    e.transmit_done = txd;
    return e;
  endfunction

  function automatic req_t random_req();
    return mk_req(func_e'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                  8'($urandom_range(0, 255)), IdxW'($urandom_range(0, MaxPayload - 1)));
  endfunction

  task automatic issue(input req_t r_in, input bit typed, input rsp_t typed_exp);
    req_t r;
    rsp_t e;
    bit   was_idle;
    bit   sending;
    int   slot;
    r = r_in;
    sending = 1'b0;
    slot = 0;
    // never let a send read a payload slot that was not loaded
    if (r.func == FN_SPI_TX) begin
      if (seq_ph == PH_WF_CMD) begin
        sending = 1'b1;
      end else if (seq_ph == PH_WF_DAT && tx_idx < frame_len()) begin
        sending = 1'b1;
        slot = tx_idx;
      end
      if (sending && !loaded[slot]) begin
        r.func = FN_LOAD_BYTE;
        r.load_index = IdxW'(slot);
      end
    end
    while ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    was_idle = (seq_ph == PH_IDLE);
    advance_sequencer(r, e);
    expected_q.push_back(typed ? typed_exp : e);
    n_req++;
    if (e.receive_done) n_rx_done++;
    if (e.transmit_done) n_tx_done++;
    if (r.func <= FN_FIFO_WRITE && !e.accepted) n_refused++;
    last_counted = !((r.func == FN_SPI_RX || r.func == FN_SPI_TX) && was_idle) &&
                   !(r.func <= FN_FIFO_WRITE && !e.accepted) &&
                   !(r.func == FN_DONE_PIN && !e.accepted && !e.transmit_done);
  endtask

  // finish any open transaction, then wait for every result
  task automatic settle();
    req_t r;
    bit   rx_turn;
    rx_turn = 1'b1;
    while (seq_ph != PH_IDLE) begin
      r = random_req();
      r.func = rx_turn ? FN_SPI_RX : FN_SPI_TX;
      rx_turn = !rx_turn;
      issue(r, 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [6:0] len, input logic [6:0] fifo,
                              input logic [6:0] mode);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_PAYLOAD_LEN;
    cfg_data_i <= len;
    @(posedge clk_i);
    cfg_idx_i <= CFG_FIFO_ADDR;
    cfg_data_i <= fifo;
    @(posedge clk_i);
    cfg_idx_i <= CFG_MODE_ADDR;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_len = len;
    cfg_fifo = fifo;
    cfg_mode = mode;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(0, 99) >= gap_pct);
  end

  always @(posedge clk_i) begin : result_check
    rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0h", $time, rsp_if.data);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("accepted", want.accepted, rsp_if.data.accepted);
        check_field("send_valid", want.send_valid, rsp_if.data.send_valid);
        check_field("send_byte", want.send_byte, rsp_if.data.send_byte);
        check_field("select_level", want.select_level, rsp_if.data.select_level);
        check_field("busy_res", want.busy_res, rsp_if.data.busy_res);
        check_field("data_kind", want.data_kind, rsp_if.data.data_kind);
        check_field("data_byte", want.data_byte, rsp_if.data.data_byte);
        check_field("data_index", want.data_index, rsp_if.data.data_index);
        check_field("receive_done", want.receive_done, rsp_if.data.receive_done);
        check_field("transmit_done", want.transmit_done, rsp_if.data.transmit_done);
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int   len_set [SettingCount];
    int   counted;
    int   pct;
    int   k;
    req_t r;
    logic [6:0] fifo;
    logic [6:0] mode;

    len_set = '{1, 64, 0, 3, 127, 2, 7};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_PAYLOAD_LEN;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;

    seq_ph = PH_IDLE;
    join_cnt = 0;
    tx_idx = 0;
    rx_idx = 0;
    reg_val = '0;
    tx_pending = 1'b0;
    cs_level = 1'b1;
    cfg_len = 7'd16;
    cfg_fifo = 7'd0;
    cfg_mode = 7'd1;
    foreach (loaded[i]) loaded[i] = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed script, frame length one so fifo frames stay short
    script.push_back('{1'b1, 7'd1, '0, 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'hFF, 0), 1'b1,
                       mk_rsp(0, 0, 8'h00, 1, 0, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_DONE_PIN, 7'd0, 8'h00, 0), 1'b1,
                       mk_rsp(1, 1, 8'h00, 0, 1, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_READ_REG, 7'h7F, 8'h00, 0), 1'b1,
                       mk_rsp(0, 0, 8'h00, 0, 1, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'hA5, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_READ_REG, 7'h7F, 8'h00, 0), 1'b1,
                       mk_rsp(1, 1, 8'h7F, 0, 1, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'hFF, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_WRITE_REG, 7'd0, 8'hFF, 0), 1'b1,
                       mk_rsp(1, 1, 8'h80, 0, 1, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_LOAD_BYTE, 7'd0, 8'h5A, 6'd63), 1'b1,
                       mk_rsp(0, 0, 8'h00, 1, 0, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_LOAD_BYTE, 7'd0, 8'hC3, 6'd0), 1'b1,
                       mk_rsp(0, 0, 8'h00, 1, 0, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_FIFO_WRITE, 7'd0, 8'h00, 0), 1'b1,
                       mk_rsp(1, 1, 8'h80, 0, 1, 0)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_DONE_PIN, 7'd0, 8'h00, 0), 1'b1,
                       mk_rsp(0, 0, 8'h00, 0, 1, 1)});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_RX, 7'd0, 8'h00, 0), 1'b0, '0});
    script.push_back('{1'b0, 7'd0, mk_req(FN_SPI_TX, 7'd0, 8'h00, 0), 1'b0, '0});

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        program_regs(script[i].len, 7'd0, 7'd1);
      end else begin
        issue(script[i].r, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < SettingCount; p++) begin
      settle();
      if (p == 0) begin
        fifo = 7'd127;
        mode = 7'd0;
      end else if (p == 1) begin
        fifo = 7'd0;
        mode = 7'd127;
      end else begin
        fifo = 7'($urandom_range(0, 127));
        mode = 7'($urandom_range(0, 127));
      end
      program_regs(7'(len_set[p]), fifo, mode);
      gap_pct = (p == 3) ? 0 : 12;
      counted = 0;
      while (counted < ItemsPerSetting) begin
        r = random_req();
        pct = $urandom_range(0, 99);
        if (seq_ph == PH_IDLE) begin
          if (pct < 70) begin
            k = $urandom_range(0, 4);
            r.func = (k == 4) ? FN_DONE_PIN : func_e'(k);
          end else if (pct < 85) begin
            r.func = FN_LOAD_BYTE;
          end else begin
            r.func = $urandom_range(0, 1) ? FN_SPI_RX : FN_SPI_TX;
          end
        end else begin
          if (pct < 80) begin
            r.func = $urandom_range(0, 1) ? FN_SPI_RX : FN_SPI_TX;
          end else if (pct < 88) begin
            r.func = FN_LOAD_BYTE;
          end else if (pct < 95) begin
            r.func = func_e'($urandom_range(0, 3));
          end else begin
            r.func = FN_DONE_PIN;
          end
        end
        issue(r, 1'b0, '0);
        if (last_counted) counted++;
      end
    end

    gap_pct = 12;
    settle();
    repeat (4) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      mismatches++;
    end

    $display("%0d requests under %0d register settings, %0d results checked",
             n_req, n_settings, n_checked);
    $display("%0d fifo reads completed, %0d transmit done pulses, %0d starts refused",
             n_rx_done, n_tx_done, n_refused);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
